// ===== rtl/mss_pkg.sv =====
package mss_pkg;

  localparam int AXIS_W    = 16;
  localparam int ADJ_W     = 8;
  localparam int FACTOR_W  = 9;
  localparam int PROD_A_W  = 25;
  localparam int PROD_W    = 32;
  localparam int SHIFT     = 8;
  localparam int FIELD_W   = 24;
  localparam int STATUS_W  = 2;
  localparam int OVF_BIT   = 3;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ADJ_W-1:0]    UNITY_ADJ  = 8'd128;
  localparam logic [ADJ_W-1:0]    ADJ_ZEROS  = 8'h00;
  localparam logic [ADJ_W-1:0]    ADJ_ONES   = 8'hFF;
  localparam logic signed [8:0]   SCALE_NT   = 9'sd150;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_DATA  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ADJ_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADJ_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADJ_Z = 2'd2;

  typedef struct packed {
    logic adv_a;
    logic adv_b;
    logic adv_c;
  } stage_en_t;

endpackage

// ===== rtl/mss_lane.sv =====
module mss_lane (
  input  logic                                clk,
  input  mss_pkg::stage_en_t                  en,
  input  logic signed [mss_pkg::AXIS_W-1:0]   count,
  input  logic [mss_pkg::FACTOR_W-1:0]        factor,
  output logic signed [mss_pkg::PROD_W-1:0]   prod
);

  logic signed [mss_pkg::AXIS_W+mss_pkg::FACTOR_W:0] mul_a;
  logic signed [mss_pkg::PROD_A_W-1:0]               prod_a;
  logic signed [mss_pkg::PROD_A_W+8:0]               mul_b;

  // count times (adj + 128)
  assign mul_a = count * $signed({1'b0, factor});

  always_ff @(posedge clk) begin
    if (en.adv_a) begin
      prod_a <= mul_a[mss_pkg::PROD_A_W-1:0];
    end
  end

  // times 150 nT per scaled count
  assign mul_b = prod_a * mss_pkg::SCALE_NT;

  always_ff @(posedge clk) begin
    if (en.adv_b) begin
      prod <= mul_b[mss_pkg::PROD_W-1:0];
    end
  end

endmodule

// ===== rtl/mss_merge.sv =====
module mss_merge (
  input  logic                                  clk,
  input  mss_pkg::stage_en_t                    en,
  input  logic [mss_pkg::STATUS_W-1:0]          status_b,
  input  logic signed [mss_pkg::PROD_W-1:0]     prod_x,
  input  logic signed [mss_pkg::PROD_W-1:0]     prod_y,
  input  logic signed [mss_pkg::PROD_W-1:0]     prod_z,
  output logic [mss_pkg::OUT_DATA_W-1:0]        tdata,
  output logic [mss_pkg::STATUS_W-1:0]          tuser
);

  logic [mss_pkg::FIELD_W-1:0] bow;
  logic [mss_pkg::FIELD_W-1:0] starboard;
  logic [mss_pkg::FIELD_W-1:0] down;

  // floor shift by 8 is the upper bits; board frame remap
  always_comb begin
    bow       = prod_y[mss_pkg::PROD_W-1:mss_pkg::SHIFT];
    starboard = -prod_x[mss_pkg::PROD_W-1:mss_pkg::SHIFT];
    down      = prod_z[mss_pkg::PROD_W-1:mss_pkg::SHIFT];
    if (status_b != mss_pkg::STATUS_OK) begin
      bow       = '0;
      starboard = '0;
      down      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.adv_c) begin
      tuser <= status_b;
      tdata <= {down, starboard, bow};
    end
  end

endmodule

// ===== rtl/magnetometer_sample_scaler.sv =====
// Magnetometer sample scaler: takes one raw reading per transaction (three signed
// 16-bit axis counts, the second status byte, data-ready in tuser) and returns
// status in tuser and bow, starboard and down fields in nanotesla in tdata.
// Each axis is scaled as count*(adj+128)*150 >>> 8 with the factory adjustment
// bytes written on the cfg port (index 0..2 = x, y, z; all 0x00 or all 0xFF
// means unity). Three axis lanes each hold two registered multiplier stages,
// followed by a merge register that presents the result; a new reading can be
// taken every cycle while the sink does not stall, and the output register
// holds a result while the sink stalls and earlier stages keep filling.
// Adjustment bytes are to be written only while no transaction is in flight.
module magnetometer_sample_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // raw_x, raw_y, raw_z, status_two
  input  logic [mss_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // data_ready
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // field_bow, field_starboard, field_down
  output logic [mss_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // status
  output logic [mss_pkg::STATUS_W-1:0]         m_axis_tuser,
  input  logic                                 cfg_we,
  input  logic [mss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mss_pkg::ADJ_W-1:0]            cfg_data
);

  logic [mss_pkg::ADJ_W-1:0]    sens_adj_x;
  logic [mss_pkg::ADJ_W-1:0]    sens_adj_y;
  logic [mss_pkg::ADJ_W-1:0]    sens_adj_z;
  logic                         force_unity;
  logic [mss_pkg::FACTOR_W-1:0] factor_x;
  logic [mss_pkg::FACTOR_W-1:0] factor_y;
  logic [mss_pkg::FACTOR_W-1:0] factor_z;

  logic                         valid_a;
  logic                         valid_b;
  logic                         valid_c;
  mss_pkg::stage_en_t           en;
  logic [mss_pkg::STATUS_W-1:0] status_in;
  logic [mss_pkg::STATUS_W-1:0] status_a;
  logic [mss_pkg::STATUS_W-1:0] status_b;

  logic signed [mss_pkg::PROD_W-1:0] prod_x;
  logic signed [mss_pkg::PROD_W-1:0] prod_y;
  logic signed [mss_pkg::PROD_W-1:0] prod_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_adj_x <= mss_pkg::UNITY_ADJ;
      sens_adj_y <= mss_pkg::UNITY_ADJ;
      sens_adj_z <= mss_pkg::UNITY_ADJ;
    end else if (cfg_we) begin
      case (cfg_index)
        mss_pkg::REG_ADJ_X: sens_adj_x <= cfg_data;
        mss_pkg::REG_ADJ_Y: sens_adj_y <= cfg_data;
        mss_pkg::REG_ADJ_Z: sens_adj_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign force_unity =
    (sens_adj_x == mss_pkg::ADJ_ZEROS && sens_adj_y == mss_pkg::ADJ_ZEROS &&
     sens_adj_z == mss_pkg::ADJ_ZEROS) ||
    (sens_adj_x == mss_pkg::ADJ_ONES && sens_adj_y == mss_pkg::ADJ_ONES &&
     sens_adj_z == mss_pkg::ADJ_ONES);

  assign factor_x = {1'b0, (force_unity ? mss_pkg::UNITY_ADJ : sens_adj_x)} +
                    {1'b0, mss_pkg::UNITY_ADJ};
  assign factor_y = {1'b0, (force_unity ? mss_pkg::UNITY_ADJ : sens_adj_y)} +
                    {1'b0, mss_pkg::UNITY_ADJ};
  assign factor_z = {1'b0, (force_unity ? mss_pkg::UNITY_ADJ : sens_adj_z)} +
                    {1'b0, mss_pkg::UNITY_ADJ};

  always_comb begin
    if (!s_axis_tuser[0]) begin
      status_in = mss_pkg::STATUS_NO_DATA;
    end else if (s_axis_tdata[3*mss_pkg::AXIS_W+mss_pkg::OVF_BIT]) begin
      status_in = mss_pkg::STATUS_OVERFLOW;
    end else begin
      status_in = mss_pkg::STATUS_OK;
    end
  end

  // stall only where the stage ahead is full and not moving
  assign en.adv_c      = valid_b && (!valid_c || m_axis_tready);
  assign en.adv_b      = valid_a && (!valid_b || en.adv_c);
  assign s_axis_tready = !valid_a || en.adv_b;
  assign en.adv_a      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      if (en.adv_a) begin
        valid_a <= 1'b1;
      end else if (en.adv_b) begin
        valid_a <= 1'b0;
      end
      if (en.adv_b) begin
        valid_b <= 1'b1;
      end else if (en.adv_c) begin
        valid_b <= 1'b0;
      end
      if (en.adv_c) begin
        valid_c <= 1'b1;
      end else if (m_axis_tready) begin
        valid_c <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.adv_a) begin
      status_a <= status_in;
    end
    if (en.adv_b) begin
      status_b <= status_a;
    end
  end

  mss_lane u_lane_x (
    .clk    (clk),
    .en     (en),
    .count  ($signed(s_axis_tdata[mss_pkg::AXIS_W-1:0])),
    .factor (factor_x),
    .prod   (prod_x)
  );

  mss_lane u_lane_y (
    .clk    (clk),
    .en     (en),
    .count  ($signed(s_axis_tdata[2*mss_pkg::AXIS_W-1:mss_pkg::AXIS_W])),
    .factor (factor_y),
    .prod   (prod_y)
  );

  mss_lane u_lane_z (
    .clk    (clk),
    .en     (en),
    .count  ($signed(s_axis_tdata[3*mss_pkg::AXIS_W-1:2*mss_pkg::AXIS_W])),
    .factor (factor_z),
    .prod   (prod_z)
  );

  mss_merge u_merge (
    .clk      (clk),
    .en       (en),
    .status_b (status_b),
    .prod_x   (prod_x),
    .prod_y   (prod_y),
    .prod_z   (prod_z),
    .tdata    (m_axis_tdata),
    .tuser    (m_axis_tuser)
  );

  assign m_axis_tvalid = valid_c;

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != mss_pkg::STATUS_OK |-> m_axis_tdata == '0)
    else $error("non-valid sample carries nonzero field");

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !valid_a |-> s_axis_tready)
    else $error("input stalled with empty first stage");

  a_hold_b: assert property (@(posedge clk) disable iff (rst)
    valid_b && !en.adv_c |=> valid_b && $stable(status_b))
    else $error("stage b lost a blocked transaction");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    en.adv_a |=> valid_a)
    else $error("accepted transaction not held in stage a");

endmodule
